[sv/rrf_pkg.sv]
package rrf_pkg;

   localparam int MAX_TOP_DEFAULT     = 32;
   localparam int TABLE_DEPTH_DEFAULT = 128;

   localparam int DOC_W    = 64;
   localparam int SCORE_W  = 26;
   localparam int QUO_W    = 25;
   localparam int OFFSET_W = 10;
   localparam int COUNT_W  = 6;
   localparam int CSR_W    = 10;

   localparam logic [SCORE_W-1:0] SCORE_CAP     = 26'd33554432;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd60;
   localparam logic [COUNT_W-1:0] COUNT_RESET   = 6'd10;

   localparam logic [1:0] REQ_LEXICAL = 2'd0;
   localparam logic [1:0] REQ_VECTOR  = 2'd1;
   localparam logic [1:0] REQ_FINISH  = 2'd2;

   localparam logic CSR_RANK_OFFSET  = 1'b0;
   localparam logic CSR_RESULT_COUNT = 1'b1;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic div_step;
      logic scan;
      logic select;
      logic write_hit;
      logic write_new;
      logic emit_load;
      logic clear;
   } rrf_cmd_type;

   typedef struct packed {
      logic entry_ok;
      logic is_finish;
      logic emit_empty;
      logic div_last;
      logic hit;
      logic scan_done;
      logic rsp_free;
      logic last;
   } rrf_status_type;

endpackage

[sv/reciprocal_rank_fusion.sv]
// Entry transfer: a load step, the bit-serial reciprocal divider, a scan of the
// table memory at one entry per cycle (stops at the hit), and one write step.
// Ignored entries take only the load step. Finish transfer: a maximum search for
// each result, held until the output is free, then one clear (at once if empty).
// One item is processed at a time. Synchronous active-high reset restores
// the registers (offset 60, count 10) and empties the table; no clearing pass.
module reciprocal_rank_fusion #(
   parameter int MAX_TOP     = rrf_pkg::MAX_TOP_DEFAULT,
   parameter int TABLE_DEPTH = rrf_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [rrf_pkg::DOC_W-1:0]     req_document,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [rrf_pkg::CSR_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rrf_pkg::DOC_W-1:0]     rsp_result_document,
   output logic [rrf_pkg::SCORE_W-1:0]   rsp_fused_score,
   output logic                          rsp_final_flag
);
   import rrf_pkg::*;

   // The controller sequences divide, search, update and emit phases; the
   // datapath holds the table memories, the divider and the result register.
   rrf_cmd_type    cmd;
   rrf_status_type st;

   rrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // A result waits in the output register while the next transfer proceeds.
   rrf_dp #(.MAX_TOP(MAX_TOP), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_type            (req_type),
      .req_document        (req_document),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_document (rsp_result_document),
      .rsp_fused_score     (rsp_fused_score),
      .rsp_final_flag      (rsp_final_flag),
      .cmd                 (cmd),
      .st                  (st)
   );

endmodule

[sv/rrf_ram.sv]
module rrf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/rrf_ctrl.sv]
module rrf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rrf_pkg::rrf_status_type st,
   output rrf_pkg::rrf_cmd_type    cmd
);
   import rrf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_DIVIDE = 8'b00000010,
      ST_SEARCH = 8'b00000100,
      ST_UPDATE = 8'b00001000,
      ST_INSERT = 8'b00010000,
      ST_SELECT = 8'b00100000,
      ST_EMIT   = 8'b01000000,
      ST_CLEAR  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (st.entry_ok) begin
                  state_in = ST_DIVIDE;
               end else if (st.is_finish) begin
                  if (st.emit_empty) begin
                     state_in = ST_CLEAR;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SELECT;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (st.hit) begin
               state_in = ST_UPDATE;
            end else if (st.scan_done) begin
               state_in = ST_INSERT;
            end
         end
         ST_UPDATE: begin
            cmd.write_hit = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_INSERT: begin
            cmd.write_new = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SELECT: begin
            cmd.scan   = 1'b1;
            cmd.select = 1'b1;
            if (st.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (st.rsp_free) begin
               cmd.emit_load = 1'b1;
               if (st.last) begin
                  state_in = ST_CLEAR;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SELECT;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/rrf_dp.sv]
module rrf_dp #(
   parameter int MAX_TOP     = rrf_pkg::MAX_TOP_DEFAULT,
   parameter int TABLE_DEPTH = rrf_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_type,
   input  logic [rrf_pkg::DOC_W-1:0]    req_document,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [rrf_pkg::CSR_W-1:0]    csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rrf_pkg::DOC_W-1:0]    rsp_result_document,
   output logic [rrf_pkg::SCORE_W-1:0]  rsp_fused_score,
   output logic                         rsp_final_flag,
   input  rrf_pkg::rrf_cmd_type         cmd,
   output rrf_pkg::rrf_status_type      st
);
   import rrf_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TOP_W = $clog2(MAX_TOP + 1);
   localparam int POS_W = $clog2(2 * MAX_TOP + 1);
   localparam int DIV_W = ((OFFSET_W > POS_W) ? OFFSET_W : POS_W) + 1;
   localparam int STEP_W = $clog2(QUO_W);

   // Configuration registers.
   logic [OFFSET_W-1:0] rank_offset_ff;
   logic [COUNT_W-1:0]  result_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_offset_ff  <= OFFSET_RESET;
         result_count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_RANK_OFFSET) begin
            rank_offset_ff <= csr_wdata[OFFSET_W-1:0];
         end else begin
            result_count_ff <= csr_wdata[COUNT_W-1:0];
         end
      end
   end

   assign csr_ready = 1'b1;

   // Effective top count and per-list limit.
   logic [TOP_W-1:0] eff_top;
   logic [POS_W-1:0] limit;

   always_comb begin
      if (result_count_ff == '0) begin
         eff_top = TOP_W'(1);
      end else if (16'(result_count_ff) > 16'(MAX_TOP)) begin
         eff_top = TOP_W'(MAX_TOP);
      end else begin
         eff_top = TOP_W'(result_count_ff);
      end
      limit = POS_W'(16'(eff_top) << 1);
   end

   // List positions and the entry being processed.
   logic [POS_W-1:0] lex_pos_ff, vec_pos_ff, pos_sel;
   logic [DOC_W-1:0] doc_ff;
   logic [CNT_W-1:0] count_ff;
   logic             lex_ok, vec_ok;

   assign lex_ok  = (req_type == REQ_LEXICAL) && (lex_pos_ff < limit);
   assign vec_ok  = (req_type == REQ_VECTOR) && (vec_pos_ff < limit);
   assign pos_sel = (req_type == REQ_LEXICAL) ? lex_pos_ff : vec_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_pos_ff <= '0;
         vec_pos_ff <= '0;
      end else if (cmd.clear) begin
         lex_pos_ff <= '0;
         vec_pos_ff <= '0;
      end else if (cmd.load) begin
         if (lex_ok) begin
            lex_pos_ff <= lex_pos_ff + 1'b1;
         end
         if (vec_ok) begin
            vec_pos_ff <= vec_pos_ff + 1'b1;
         end
      end
   end

   // Restoring divider: 2^24 / (rank_offset + rank), one quotient bit per cycle.
   logic [DIV_W-1:0]  divisor_ff, rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W:0]    rem_shift;

   assign rem_shift = {rem_ff, (step_ff == '0)};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         doc_ff     <= req_document;
         divisor_ff <= DIV_W'(rank_offset_ff) + DIV_W'(pos_sel) + 1'b1;
         rem_ff     <= '0;
         quo_ff     <= '0;
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, divisor_ff}) begin
            rem_ff <= DIV_W'(rem_shift - {1'b0, divisor_ff});
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= DIV_W'(rem_shift);
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         step_ff <= step_ff + 1'b1;
      end
   end

   // Table memories and the scan pipeline.
   logic [DOC_W-1:0]   id_rdata;
   logic [SCORE_W-1:0] score_rdata;
   logic               id_we, score_we;
   logic [AW-1:0]      waddr;
   logic [SCORE_W-1:0] score_wdata;
   logic [CNT_W-1:0]   scan_ptr_ff;
   logic               rd_valid_ff;
   logic [AW-1:0]      rd_idx_ff;
   logic               issue, match;

   assign issue = cmd.scan && (scan_ptr_ff < count_ff);
   assign match = rd_valid_ff && (id_rdata == doc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         rd_valid_ff <= 1'b0;
      end else if (cmd.scan) begin
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ptr_ff <= '0;
      end else if (issue) begin
         scan_ptr_ff <= scan_ptr_ff + 1'b1;
      end
      rd_idx_ff <= scan_ptr_ff[AW-1:0];
   end

   // Hit capture for the score update.
   logic [AW-1:0]      hit_idx_ff;
   logic [SCORE_W-1:0] hit_score_ff;
   logic [SCORE_W:0]   sum;

   always_ff @(posedge clock) begin
      if (cmd.scan && !cmd.select && match) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_score_ff <= score_rdata;
      end
   end

   assign sum = {1'b0, hit_score_ff} + (SCORE_W + 1)'(quo_ff);

   always_comb begin
      id_we       = 1'b0;
      score_we    = 1'b0;
      waddr       = count_ff[AW-1:0];
      score_wdata = SCORE_W'(quo_ff);
      if (cmd.write_hit) begin
         score_we = 1'b1;
         waddr    = hit_idx_ff;
         score_wdata = (sum > (SCORE_W + 1)'(SCORE_CAP)) ? SCORE_CAP : SCORE_W'(sum);
      end else if (cmd.write_new && (count_ff < CNT_W'(TABLE_DEPTH))) begin
         id_we    = 1'b1;
         score_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (id_we) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   rrf_ram #(.WIDTH(DOC_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
      .clock (clock),
      .we    (id_we),
      .waddr (waddr),
      .wdata (doc_ff),
      .raddr (scan_ptr_ff[AW-1:0]),
      .rdata (id_rdata)
   );

   rrf_ram #(.WIDTH(SCORE_W), .DEPTH(TABLE_DEPTH)) u_score_ram (
      .clock (clock),
      .we    (score_we),
      .waddr (waddr),
      .wdata (score_wdata),
      .raddr (scan_ptr_ff[AW-1:0]),
      .rdata (score_rdata)
   );

   // Maximum search over untaken entries; earlier index wins ties.
   logic [TABLE_DEPTH-1:0] taken_ff;
   logic                   found_ff;
   logic [AW-1:0]          best_idx_ff;
   logic [SCORE_W-1:0]     best_score_ff;
   logic [DOC_W-1:0]       best_id_ff;
   logic [CNT_W-1:0]       left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         found_ff <= 1'b0;
      end else if (cmd.select && rd_valid_ff && !taken_ff[rd_idx_ff]) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select && rd_valid_ff && !taken_ff[rd_idx_ff]
          && (!found_ff || (score_rdata > best_score_ff))) begin
         best_idx_ff   <= rd_idx_ff;
         best_score_ff <= score_rdata;
         best_id_ff    <= id_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
      end else if (cmd.load) begin
         taken_ff <= '0;
      end else if (cmd.emit_load) begin
         taken_ff[best_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff <= (16'(eff_top) < 16'(count_ff)) ? CNT_W'(eff_top) : count_ff;
      end else if (cmd.emit_load) begin
         left_ff <= left_ff - 1'b1;
      end
   end

   // Result register.
   logic               rsp_valid_ff;
   logic [DOC_W-1:0]   rsp_doc_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic               rsp_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_doc_ff   <= best_id_ff;
         rsp_score_ff <= best_score_ff;
         rsp_final_ff <= (left_ff == CNT_W'(1));
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_document = rsp_doc_ff;
   assign rsp_fused_score     = rsp_score_ff;
   assign rsp_final_flag      = rsp_final_ff;

   always_comb begin
      st            = '0;
      st.entry_ok   = lex_ok || vec_ok;
      st.is_finish  = (req_type == REQ_FINISH);
      st.emit_empty = (count_ff == '0);
      st.div_last   = (step_ff == STEP_W'(QUO_W - 1));
      st.hit        = match;
      st.scan_done  = !issue && !rd_valid_ff;
      st.rsp_free   = !rsp_valid_ff || rsp_ready;
      st.last       = (left_ff == CNT_W'(1));
   end

endmodule

[sv/rrf_checker.sv]
module rrf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_type,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rrf_pkg::DOC_W-1:0]    rsp_result_document,
   input logic [rrf_pkg::SCORE_W-1:0]  rsp_fused_score
);
   import rrf_pkg::*;

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_document)
         && $stable(rsp_fused_score))
      else $error("result changed while stalled");

   // Every emitted score is a nonzero sum within the saturation cap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fused_score != '0) && (rsp_fused_score <= SCORE_CAP))
      else $error("score out of range");

   // A finish transfer always leaves the block not ready for a new request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_FINISH) |=> !req_ready)
      else $error("ready right after finish");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind reciprocal_rank_fusion rrf_checker u_rrf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_type            (req_type),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_result_document (rsp_result_document),
   .rsp_fused_score     (rsp_fused_score)
);

[tb/reciprocal_rank_fusion_tb.sv]
`timescale 1ns / 100ps

module reciprocal_rank_fusion_tb;
   import rrf_pkg::*;

   // Request code that the block must ignore; the package names only the legal ones.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int MAX_TOP      = MAX_TOP_DEFAULT;
   localparam int TABLE_DEPTH  = TABLE_DEPTH_DEFAULT;
   localparam int SCORE_ONE    = 16777216;
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT  = 3000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type = REQ_LEXICAL;
   logic [DOC_W-1:0]    req_document = '0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_RANK_OFFSET;
   logic [CSR_W-1:0]    csr_wdata = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DOC_W-1:0]    rsp_result_document;
   logic [SCORE_W-1:0]  rsp_fused_score;
   logic                rsp_final_flag;

   reciprocal_rank_fusion dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_document        (req_document),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_document (rsp_result_document),
      .rsp_fused_score     (rsp_fused_score),
      .rsp_final_flag      (rsp_final_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One fused result as the block should deliver it.
   typedef struct {
      logic [DOC_W-1:0]   document;
      logic [SCORE_W-1:0] score;
      logic               final_flag;
   } ranked_doc_type;

   ranked_doc_type ranked_expect[$];

   // Shadow of the block: its registers, its score table and its list counters.
   logic [OFFSET_W-1:0] shadow_offset;
   logic [COUNT_W-1:0]  shadow_count;
   logic [DOC_W-1:0]    shadow_ids[TABLE_DEPTH];
   logic [SCORE_W-1:0]  shadow_scores[TABLE_DEPTH];
   int                  shadow_entries;
   int                  shadow_lex_pos;
   int                  shadow_vec_pos;

   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  rsp_stall_on = 1'b0;
   bit  send_gaps_on = 1'b0;
   int  burst_left = 0;
   int  stall_tick = 0;
   int  stall_period = 4;
   int  stall_open = 2;
   logic [DOC_W-1:0] doc_pool[8];

   function automatic int effective_top();
      int t;
      t = shadow_count;
      if (t < 1) t = 1;
      if (t > MAX_TOP) t = MAX_TOP;
      return t;
   endfunction

   // Add the reciprocal-rank share of one entry to its document's score.
   task automatic fuse_entry(input logic [DOC_W-1:0] doc, input int rank);
      int divisor;
      int share;
      int sum;
      divisor = shadow_offset + rank;
      share = SCORE_ONE / divisor;
      for (int i = 0; i < shadow_entries; i++) begin
         if (shadow_ids[i] == doc) begin
            sum = shadow_scores[i] + share;
            shadow_scores[i] = (sum > SCORE_CAP) ? SCORE_CAP : SCORE_W'(sum);
            return;
         end
      end
      if (shadow_entries < TABLE_DEPTH) begin
         shadow_ids[shadow_entries] = doc;
         shadow_scores[shadow_entries] = (share > SCORE_CAP) ? SCORE_CAP : SCORE_W'(share);
         shadow_entries++;
      end
   endtask

   // Selection sort by descending score; strict compare keeps insertion order on ties.
   task automatic emit_ranking();
      bit taken[TABLE_DEPTH];
      int top;
      int best;
      bit found;
      ranked_doc_type item;
      top = effective_top();
      if (top > shadow_entries) top = shadow_entries;
      foreach (taken[i]) taken[i] = 1'b0;
      for (int k = 0; k < top; k++) begin
         best = 0;
         found = 1'b0;
         for (int i = 0; i < shadow_entries; i++) begin
            if (!taken[i] && (!found || shadow_scores[i] > shadow_scores[best])) begin
               best = i;
               found = 1'b1;
            end
         end
         taken[best] = 1'b1;
         item.document = shadow_ids[best];
         item.score = shadow_scores[best];
         item.final_flag = (k + 1 == top);
         ranked_expect = {ranked_expect, item};
      end
      shadow_entries = 0;
      shadow_lex_pos = 0;
      shadow_vec_pos = 0;
   endtask

   task automatic predict_request(input logic [1:0] kind, input logic [DOC_W-1:0] doc);
      int limit;
      limit = 2 * effective_top();
      case (kind)
         REQ_LEXICAL: begin
            if (shadow_lex_pos < limit) begin
               shadow_lex_pos++;
               fuse_entry(doc, shadow_lex_pos);
            end
         end
         REQ_VECTOR: begin
            if (shadow_vec_pos < limit) begin
               shadow_vec_pos++;
               fuse_entry(doc, shadow_vec_pos);
            end
         end
         REQ_FINISH: emit_ranking();
         default: ;
      endcase
   endtask

   // Sends one request. The caller stands at a rising edge. Valid stays high across
   // back-to-back transfers and is lowered only when a gap follows.
   task automatic send_request(input logic [1:0] kind, input logic [DOC_W-1:0] doc);
      int gap;
      req_valid <= 1'b1;
      req_type <= kind;
      req_document <= doc;
      do @(posedge clock); while (!req_ready);
      predict_request(kind, doc);
      if (send_gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   // Waits until every expected result has come, then lets any entry still in
   // flight finish before the block is treated as idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (ranked_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [CSR_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_RANK_OFFSET) shadow_offset = value[OFFSET_W-1:0];
      else shadow_count = value[COUNT_W-1:0];
   endtask

   function automatic logic [DOC_W-1:0] random_doc();
      return {$urandom, $urandom};
   endfunction

   // Receiver: a stall pattern of changing period and duty, or always ready.
   // The same block checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      ranked_doc_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ranked_expect.size() == 0) begin
            $error("unexpected result document=%h score=%0d",
                   rsp_result_document, rsp_fused_score);
            mismatch_count++;
         end else begin
            want = ranked_expect.pop_front();
            if (rsp_result_document !== want.document) begin
               $error("result_document expected %h actual %h",
                      want.document, rsp_result_document);
               mismatch_count++;
            end
            if (rsp_fused_score !== want.score) begin
               $error("fused_score expected %0d actual %0d", want.score, rsp_fused_score);
               mismatch_count++;
            end
            if (rsp_final_flag !== want.final_flag) begin
               $error("final_flag expected %0d actual %0d", want.final_flag, rsp_final_flag);
               mismatch_count++;
            end
         end
      end
      if (rsp_stall_on) begin
         stall_tick++;
         if (stall_tick >= stall_period) begin
            stall_tick = 0;
            stall_period = $urandom_range(2, 12);
            stall_open = $urandom_range(1, stall_period);
         end
         rsp_ready <= (stall_tick < stall_open);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog for a block that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Defaults after reset, extreme ids, a tie between the two lists, a repeat.
   task automatic test_reset_defaults();
      send_request(REQ_LEXICAL, '0);
      send_request(REQ_VECTOR, '1);
      send_request(REQ_LEXICAL, 64'hA5A5_5A5A_F00F_0FF0);
      send_request(REQ_VECTOR, '0);
      send_request(REQ_FINISH, '1);
   endtask

   // A finish with an empty table clears without results; the unused code is ignored.
   task automatic test_empty_and_unknown();
      send_request(REQ_FINISH, '0);
      send_request(REQ_UNUSED, '1);
      send_request(REQ_LEXICAL, 64'h0123_4567_89AB_CDEF);
      send_request(REQ_UNUSED, 64'h55);
      send_request(REQ_FINISH, '0);
      send_request(REQ_FINISH, '0);
   endtask

   // With a zero offset one document collects enough shares to hit the cap.
   task automatic test_saturation();
      write_register(CSR_RANK_OFFSET, '0);
      send_request(REQ_LEXICAL, 64'hDEAD_BEEF_0000_0001);
      send_request(REQ_LEXICAL, 64'hDEAD_BEEF_0000_0001);
      send_request(REQ_VECTOR, 64'hDEAD_BEEF_0000_0001);
      send_request(REQ_VECTOR, 64'h2);
      send_request(REQ_FINISH, '0);
   endtask

   // A count of zero acts as one, so each list takes two entries and one result comes.
   task automatic test_list_limit();
      write_register(CSR_RANK_OFFSET, 10'h3FF);
      write_register(CSR_RESULT_COUNT, '0);
      for (int i = 0; i < 4; i++) send_request(REQ_LEXICAL, 64'(i + 10));
      send_request(REQ_VECTOR, 64'd12);
      send_request(REQ_FINISH, '0);
   endtask

   // Every bit of the count written high saturates top_k at its maximum.
   // Both lists at full length fill the table to its last slot.
   task automatic test_full_table();
      write_register(CSR_RESULT_COUNT, 10'h3FF);
      write_register(CSR_RANK_OFFSET, 10'd1);
      for (int i = 0; i < 2 * MAX_TOP + 1; i++) send_request(REQ_LEXICAL, random_doc());
      for (int i = 0; i < 2 * MAX_TOP + 1; i++) send_request(REQ_VECTOR, random_doc());
      send_request(REQ_FINISH, '0);
   endtask

   // Queries of random shape: ids from a small pool so that the lists overlap,
   // now and then an unknown code or an entry past the limit, then a finish.
   task automatic test_random_queries(input int item_goal);
      int sent;
      int length;
      int pick;
      logic [1:0] kind;
      logic [DOC_W-1:0] doc;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1)) begin
               write_register(CSR_RANK_OFFSET, CSR_W'($urandom_range(0, 1023)));
            end else begin
               write_register(CSR_RESULT_COUNT, CSR_W'($urandom_range(0, 12)));
            end
            foreach (doc_pool[i]) doc_pool[i] = random_doc();
         end
         length = $urandom_range(0, 4 * effective_top() + 2);
         if (length > 24) length = $urandom_range(4, 24);
         for (int i = 0; i < length; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) kind = REQ_UNUSED;
            else kind = $urandom_range(0, 1) ? REQ_VECTOR : REQ_LEXICAL;
            doc = $urandom_range(0, 2) == 0 ? random_doc() : doc_pool[$urandom_range(0, 7)];
            send_request(kind, doc);
            if (kind != REQ_UNUSED) sent++;
         end
         send_request(REQ_FINISH, random_doc());
         sent++;
      end
   endtask

   initial begin
      shadow_offset = OFFSET_RESET;
      shadow_count = COUNT_RESET;
      shadow_entries = 0;
      shadow_lex_pos = 0;
      shadow_vec_pos = 0;
      foreach (doc_pool[i]) doc_pool[i] = random_doc();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_empty_and_unknown();
      rsp_stall_on = 1'b1;
      send_gaps_on = 1'b1;
      test_saturation();
      test_list_limit();
      write_register(CSR_RESULT_COUNT, 10'd10);
      write_register(CSR_RANK_OFFSET, 10'd60);
      test_random_queries(200);
      rsp_stall_on = 1'b0;
      send_gaps_on = 1'b0;
      test_random_queries(60);
      rsp_stall_on = 1'b1;
      send_gaps_on = 1'b1;
      test_random_queries(80);
      test_full_table();

      drain();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
